FILE: hw/rtl/ssh_pkg.sv
// Shared types, constants and the finishing function of the selectable string hash.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package ssh_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [HashW-1:0] RsInitA   = 32'd63689;
  localparam logic [HashW-1:0] RsStepB   = 32'd378551;
  localparam logic [HashW-1:0] JsInit    = 32'd1315423911;
  localparam logic [HashW-1:0] ElfHigh   = 32'hF000_0000;
  localparam logic [HashW-1:0] MultReset = 32'd65599;
  localparam logic [HashW-1:0] SeedReset = 32'd0;

  // Algorithm codes; codes 6 and 7 fall back to multiply-add.
  typedef enum logic [ModeW-1:0] {
    MODE_MULADD = 3'd0,
    MODE_RS     = 3'd1,
    MODE_JS     = 3'd2,
    MODE_ELF    = 3'd3,
    MODE_AP     = 3'd4,
    MODE_OAAT   = 3'd5
  } hash_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HASH_MODE   = 2'd0,
    CFG_MULT_FACTOR = 2'd1,
    CFG_SEED_VALUE  = 2'd2,
    CFG_CHAR_SIGNED = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [ModeW-1:0] hash_mode;
    logic [HashW-1:0] mult_factor;
    logic [HashW-1:0] seed_value;
    logic             char_signed;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
    logic             no_byte;
  } item_t;

  // One-at-a-time final avalanche; other modes pass the hash through.
  function automatic logic [HashW-1:0] finish_hash(input logic [HashW-1:0] h,
                                                   input logic oaat);
    logic [HashW-1:0] t;
    t = h;
    if (oaat) begin
      t = t + (t << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/ssh_cfg_regs.sv
// Configuration register file of the selectable string hash.
// Depends on ssh_pkg for the register index codes and the cfg_t bundle.
`timescale 1ns / 1ps

module ssh_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ssh_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ssh_pkg::HashW-1:0]   cfg_data_i,
  output ssh_pkg::cfg_t               cfg_o
);

  ssh_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ssh_pkg::CFG_HASH_MODE:   cfg_d.hash_mode   = cfg_data_i[ssh_pkg::ModeW-1:0];
        ssh_pkg::CFG_MULT_FACTOR: cfg_d.mult_factor = cfg_data_i;
        ssh_pkg::CFG_SEED_VALUE:  cfg_d.seed_value  = cfg_data_i;
        ssh_pkg::CFG_CHAR_SIGNED: cfg_d.char_signed = cfg_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_mode   <= ssh_pkg::MODE_MULADD;
      cfg_q.mult_factor <= ssh_pkg::MultReset;
      cfg_q.seed_value  <= ssh_pkg::SeedReset;
      cfg_q.char_signed <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/ssh_core.sv
// Running hash state and the per-byte mixing step for all algorithms.
// Depends on ssh_pkg for constants, mode codes and the cfg_t / item_t bundles.
`timescale 1ns / 1ps

module ssh_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssh_pkg::cfg_t             cfg_i,
  input  ssh_pkg::item_t            item_i,
  input  logic                      step_i,
  output logic [ssh_pkg::HashW-1:0] hash_o
);

  logic [ssh_pkg::HashW-1:0] hash_acc_q, hash_acc_d;
  logic [ssh_pkg::HashW-1:0] rs_factor_q, rs_factor_d;
  logic                      odd_q, odd_d;
  logic                      in_string_q, in_string_d;

  logic [ssh_pkg::HashW-1:0] h0, rs0, ch, mul_b, prod, rs_next, mixed, elf_t, elf_x;
  logic                      odd0;

  // Start value of a fresh string, or the running state.
  always_comb begin
    if (in_string_q) begin
      h0   = hash_acc_q;
      rs0  = rs_factor_q;
      odd0 = odd_q;
    end else begin
      rs0  = ssh_pkg::RsInitA;
      odd0 = 1'b0;
      case (cfg_i.hash_mode)
        ssh_pkg::MODE_JS:   h0 = ssh_pkg::JsInit;
        ssh_pkg::MODE_RS,
        ssh_pkg::MODE_ELF,
        ssh_pkg::MODE_AP,
        ssh_pkg::MODE_OAAT: h0 = '0;
        default:            h0 = cfg_i.seed_value;
      endcase
    end
  end

  assign ch = {{(ssh_pkg::HashW-ssh_pkg::ByteW){cfg_i.char_signed & item_i.data_byte[7]}},
               item_i.data_byte};

  // One shared multiplier for multiply-add and RS; the RS factor step is independent.
  assign mul_b   = (cfg_i.hash_mode == ssh_pkg::MODE_RS) ? rs0 : cfg_i.mult_factor;
  assign prod    = h0 * mul_b;
  assign rs_next = rs0 * ssh_pkg::RsStepB;

  assign elf_t = (h0 << 4) + ch;
  assign elf_x = elf_t & ssh_pkg::ElfHigh;

  always_comb begin
    logic [ssh_pkg::HashW-1:0] oa;
    oa = h0 + ch;
    oa = oa + (oa << 10);
    oa = oa ^ (oa >> 6);
    case (cfg_i.hash_mode)
      ssh_pkg::MODE_RS:   mixed = prod + ch;
      ssh_pkg::MODE_JS:   mixed = h0 ^ ((h0 << 5) + ch + (h0 >> 2));
      ssh_pkg::MODE_ELF:  mixed = (elf_t ^ (elf_x >> 24)) & ~elf_x;
      ssh_pkg::MODE_AP:   mixed = odd0 ? (h0 ^ ~((h0 << 11) ^ ch ^ (h0 >> 5)))
                                       : (h0 ^ ((h0 << 7) ^ ch ^ (h0 >> 3)));
      ssh_pkg::MODE_OAAT: mixed = oa;
      default:            mixed = prod + ch;
    endcase
  end

  always_comb begin
    hash_acc_d  = h0;
    rs_factor_d = rs0;
    odd_d       = odd0;
    if (!item_i.no_byte) begin
      hash_acc_d = mixed;
      if (cfg_i.hash_mode == ssh_pkg::MODE_RS) begin
        rs_factor_d = rs_next;
      end
      if (cfg_i.hash_mode == ssh_pkg::MODE_AP) begin
        odd_d = ~odd0;
      end
    end
    in_string_d = ~item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_acc_q  <= '0;
      rs_factor_q <= ssh_pkg::RsInitA;
      odd_q       <= 1'b0;
      in_string_q <= 1'b0;
    end else if (step_i) begin
      hash_acc_q  <= hash_acc_d;
      rs_factor_q <= rs_factor_d;
      odd_q       <= odd_d;
      in_string_q <= in_string_d;
    end
  end

  assign hash_o = hash_acc_d;

endmodule

FILE: hw/rtl/selectable_string_hash.sv
// Top level of the selectable string hash: input register, mixing core, result register.
// Depends on ssh_pkg, ssh_cfg_regs and ssh_core.
`timescale 1ns / 1ps

// Streams a string in one byte per word, with a last flag, and returns one
// 32-bit hash per string on the word that carries last. hash_mode selects
// multiply-add (h*mult_factor+c: SDBM, BKDR, DJB), RS, JS, ELF/PJW, AP or
// one-at-a-time with its final mix; codes 6 and 7 act as multiply-add. A word
// with no_byte set mixes nothing, so no_byte with last gives the hash of the
// empty string. Throughput is one byte per cycle while the result register has
// room for a hash, set by the single mixing step on the running state (one
// 32x32 multiplier plus the RS factor multiplier). out_valid_o rises once the
// last word has passed the input register and its hash is loaded into the
// result register; the next string's bytes flow in while a hash waits.
// Write the configuration only while no string is in flight.
module selectable_string_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ssh_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ssh_pkg::HashW-1:0]   cfg_data_i,
  // byte input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ssh_pkg::ByteW-1:0]   data_byte_i,
  input  logic                        last_i,
  input  logic                        no_byte_i,
  // hash output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ssh_pkg::HashW-1:0]   hash_value_o
);

  ssh_pkg::cfg_t             cfg;
  ssh_pkg::item_t            item_q;
  logic                      item_valid_q, item_valid_d;
  logic [ssh_pkg::HashW-1:0] mixed_hash;
  logic [ssh_pkg::HashW-1:0] out_hash_q;
  logic                      out_oaat_q;
  logic                      out_valid_q, out_valid_d;
  logic                      in_accept, out_free, step, out_load;

  ssh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Result register is free when empty or being drained this cycle.
  assign out_free = ~out_valid_q | ~out_stall_i;
  // A non-last word always advances; a last word needs room for its hash.
  assign step     = item_valid_q & (~item_q.last | out_free);
  assign out_load = step & item_q.last;

  // Hold the input word while it cannot advance.
  assign in_stall_o = item_valid_q & ~step;
  assign in_accept  = in_valid_i & ~in_stall_o;

  ssh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .step_i (step),
    .hash_o (mixed_hash)
  );

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (step) begin
      item_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.data_byte <= data_byte_i;
      item_q.last      <= last_i;
      item_q.no_byte   <= no_byte_i;
    end
    if (out_load) begin
      out_hash_q <= mixed_hash;
      out_oaat_q <= (cfg.hash_mode == ssh_pkg::MODE_OAAT);
    end
  end

  // Apply the one-at-a-time avalanche on the way out.
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = ssh_pkg::finish_hash(out_hash_q, out_oaat_q);

endmodule

FILE: test/tb_selectable_string_hash.sv
// Self-checking testbench for selectable_string_hash: directed table, then random strings.
// Depends on ssh_pkg (codes, widths, constants) and the selectable_string_hash RTL.
`timescale 1ns / 1ps

module tb_selectable_string_hash;

  import ssh_pkg::*;

  // Directed table: a row either writes a register or sends one word.
  // Where 'fixed' is set, 'value' is the hash the string must give.
  typedef enum logic {
    STEP_WORD = 1'b0,
    STEP_CFG  = 1'b1
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    cfg_index_e       idx;
    logic [HashW-1:0] value;
    logic [ByteW-1:0] data;
    logic             lst;
    logic             nob;
    logic             fixed;
  } step_t;

  localparam int unsigned PlanLen = 32;
  localparam int unsigned RandWords = 1050;

  localparam step_t Plan [PlanLen] = '{
    // reset settings: multiply-add, SDBM multiplier, seed 0, signed characters
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h00, 1'b1, 1'b1, 1'b1}, // empty string
    '{STEP_WORD, CFG_HASH_MODE,   32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 1'b1}, // sign-extended
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h7F, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h00, 1'b0, 1'b0, 1'b0}, // zero byte mixes
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h5A, 1'b0, 1'b1, 1'b0}, // carries nothing
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h80, 1'b1, 1'b0, 1'b0},
    '{STEP_CFG,  CFG_CHAR_SIGNED, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_00FF, 8'hFF, 1'b1, 1'b0, 1'b1}, // zero-extended
    '{STEP_CFG,  CFG_MULT_FACTOR, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_CFG,  CFG_SEED_VALUE,  32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'hFFFF_FFFF, 8'h33, 1'b1, 1'b1, 1'b1}, // empty gives seed
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0012, 8'h12, 1'b1, 1'b0, 1'b1}, // multiplier zero
    '{STEP_CFG,  CFG_HASH_MODE,   32'(MODE_RS),  8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h61, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h62, 1'b1, 1'b0, 1'b0},
    '{STEP_CFG,  CFG_HASH_MODE,   32'(MODE_JS),  8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h4E67_C6A7, 8'hC3, 1'b1, 1'b1, 1'b1}, // JS start value
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'hAA, 1'b1, 1'b0, 1'b0},
    '{STEP_CFG,  CFG_HASH_MODE,   32'(MODE_ELF), 8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0041, 8'h41, 1'b1, 1'b0, 1'b1},
    '{STEP_CFG,  CFG_HASH_MODE,   32'(MODE_AP),  8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h31, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h32, 1'b1, 1'b0, 1'b0},
    '{STEP_CFG,  CFG_HASH_MODE,   32'(MODE_OAAT), 8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h0F, 1'b1, 1'b1, 1'b1}, // mix of zero
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h61, 1'b1, 1'b0, 1'b0},
    '{STEP_CFG,  CFG_HASH_MODE,   32'h0000_0007, 8'h00, 1'b0, 1'b0, 1'b0}, // unused code
    '{STEP_CFG,  CFG_CHAR_SIGNED, 32'h0000_0001, 8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_CFG,  CFG_MULT_FACTOR, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'hFFFF_FF81, 8'h80, 1'b1, 1'b0, 1'b1}, // -1 * -1 - 128
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{STEP_WORD, CFG_HASH_MODE,   32'h0000_0000, 8'h02, 1'b1, 1'b0, 1'b0}
  };

  // Every input of the block starts at a known value.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [HashW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               last_i      = 1'b0;
  logic               no_byte_i   = 1'b0;
  logic               out_stall_i = 1'b0;
  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [HashW-1:0]   hash_value_o;

  // Shadow of the configuration registers.
  logic [ModeW-1:0]   cur_mode   = MODE_MULADD;
  logic [HashW-1:0]   cur_mult   = MultReset;
  logic [HashW-1:0]   cur_seed   = SeedReset;
  logic               cur_signed = 1'b1;

  // Shadow of the running hash state.
  logic [HashW-1:0]   run_hash   = '0;
  logic [HashW-1:0]   rs_mul     = RsInitA;
  logic               ap_odd     = 1'b0;
  logic               str_open   = 1'b0;

  logic [HashW-1:0]   pending_hashes [$];
  int unsigned        mismatches = 0;
  int unsigned        stall_run  = 0;
  logic               quiet_phase = 1'b0;

  selectable_string_hash u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .no_byte_i    (no_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Fold one accepted word into the shadow state; a word with last queues the
  // finished hash (or the typed-in value where the table fixes it).
  task automatic absorb_word(input logic [ByteW-1:0] data, input logic lst, input logic nob,
                             input logic fixed, input logic [HashW-1:0] fixed_hash);
    logic [HashW-1:0] c;
    logic [HashW-1:0] h;
    logic [HashW-1:0] x;
    if (!str_open) begin
      case (cur_mode)
        MODE_JS: run_hash = JsInit;
        MODE_RS, MODE_ELF, MODE_AP, MODE_OAAT: run_hash = '0;
        default: run_hash = cur_seed;
      endcase
      rs_mul   = RsInitA;
      ap_odd   = 1'b0;
      str_open = 1'b1;
    end
    if (!nob) begin
      c = {{(HashW-ByteW){cur_signed & data[ByteW-1]}}, data};
      h = run_hash;
      case (cur_mode)
        MODE_RS: begin
          h      = h * rs_mul + c;
          rs_mul = rs_mul * RsStepB;
        end
        MODE_JS: h = h ^ ((h << 5) + c + (h >> 2));
        MODE_ELF: begin
          h = (h << 4) + c;
          x = h & ElfHigh;
          if (x != '0) begin
            h = h ^ (x >> 24);
            h = h & ~x;
          end
        end
        MODE_AP: begin
          // alternate the two AP mixes on even and odd characters
          if (!ap_odd) h = h ^ ((h << 7) ^ c ^ (h >> 3));
          else h = h ^ ~((h << 11) ^ c ^ (h >> 5));
          ap_odd = ~ap_odd;
        end
        MODE_OAAT: begin
          h = h + c;
          h = h + (h << 10);
          h = h ^ (h >> 6);
        end
        default: h = h * cur_mult + c;
      endcase
      run_hash = h;
    end
    if (lst) begin
      h = run_hash;
      if (cur_mode == MODE_OAAT) begin
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
      end
      pending_hashes.push_back(fixed ? fixed_hash : h);
      str_open = 1'b0;
    end
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Bias towards zero and all-ones, which hit sign extension and the zero byte.
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(8'h80 | $urandom_range(0, 127));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one word and hold it until the block takes it. Acceptance is
  // decided on the falling edge, where valid and stall are settled.
  task automatic send_word(input logic [ByteW-1:0] data, input logic lst, input logic nob,
                           input logic fixed, input logic [HashW-1:0] fixed_hash);
    logic took;
    int   gap;
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_i      <= lst;
    no_byte_i   <= nob;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = !in_stall_o;
      if (took) absorb_word(data, lst, nob, fixed, fixed_hash);
      @(posedge clk_i);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every hash still owed, then let the pipeline empty
  // of words that end no string.
  task automatic drain_hashes();
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_index_e idx, input logic [HashW-1:0] data);
    logic took;
    drain_hashes();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = cfg_ready_o;
      if (took) begin
        case (idx)
          CFG_HASH_MODE:   cur_mode   = data[ModeW-1:0];
          CFG_MULT_FACTOR: cur_mult   = data;
          CFG_SEED_VALUE:  cur_seed   = data;
          CFG_CHAR_SIGNED: cur_signed = data[0];
          default: ;
        endcase
      end
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver stalls: short bursts, occasional long hold-offs, and free stretches.
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall_i <= 1'b1;
          stall_run   <= $urandom_range(10, 40);
        end
        1, 2: begin
          out_stall_i <= 1'b0;
          stall_run   <= $urandom_range(40, 150);
        end
        3, 4, 5, 6, 7, 8, 9: begin
          out_stall_i <= 1'b1;
          stall_run   <= $urandom_range(0, 2);
        end
        default: begin
          out_stall_i <= 1'b0;
          stall_run   <= $urandom_range(0, 5);
        end
      endcase
    end
  end

  // Check each hash the receiver takes against the oldest one owed.
  always @(negedge clk_i) begin : check_hash
    logic [HashW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        $error("hash_value: no string ended, got %08h", hash_value_o);
        mismatches++;
      end else begin
        want = pending_hashes.pop_front();
        if (hash_value_o !== want) begin
          $error("hash_value: expected %08h, got %08h", want, hash_value_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int               words_left;
    int               n_str;
    int               len;
    int               r;
    logic             end_bare;
    logic             first_phase;
    logic [ModeW-1:0] mode;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: walk the table; register rows drain the block first.
    for (int i = 0; i < PlanLen; i++) begin
      if (Plan[i].kind == STEP_CFG) write_cfg(Plan[i].idx, Plan[i].value);
      else send_word(Plan[i].data, Plan[i].lst, Plan[i].nob, Plan[i].fixed, Plan[i].value);
    end

    // Random part: each phase picks new settings, then streams whole strings.
    // The drain before each register write is where the sender waits for
    // every hash owed.
    words_left  = RandWords;
    first_phase = 1'b1;
    while (words_left > 0) begin
      r    = $urandom_range(0, 15);
      mode = (r < 14) ? ModeW'(r % 6) : ModeW'(r - 8);
      write_cfg(CFG_HASH_MODE, {29'($urandom), mode});
      if (first_phase || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 6))
          0: write_cfg(CFG_MULT_FACTOR, MultReset);
          1: write_cfg(CFG_MULT_FACTOR, 32'd131);
          2: write_cfg(CFG_MULT_FACTOR, 32'd33);
          3: write_cfg(CFG_MULT_FACTOR, 32'd0);
          4: write_cfg(CFG_MULT_FACTOR, 32'd1);
          5: write_cfg(CFG_MULT_FACTOR, 32'hFFFF_FFFF);
          default: write_cfg(CFG_MULT_FACTOR, $urandom);
        endcase
      end
      if (first_phase || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 4))
          0: write_cfg(CFG_SEED_VALUE, 32'd0);
          1: write_cfg(CFG_SEED_VALUE, 32'd5381);
          2: write_cfg(CFG_SEED_VALUE, 32'hFFFF_FFFF);
          default: write_cfg(CFG_SEED_VALUE, $urandom);
        endcase
      end
      if (first_phase || $urandom_range(0, 1) == 1)
        write_cfg(CFG_CHAR_SIGNED, $urandom);
      first_phase = 1'b0;
      quiet_phase = ($urandom_range(0, 3) == 0);

      n_str = $urandom_range(3, 10);
      for (int s = 0; s < n_str; s++) begin
        r = $urandom_range(0, 99);
        if (r < 5) len = 0;
        else if (r < 70) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 24);
        else len = $urandom_range(25, 60);
        // some strings end on a bare last word instead of on a character
        end_bare = (len == 0) || ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_word(pick_byte(), 1'b0, 1'b1, 1'b0, '0);
            words_left--;
          end
          send_word(pick_byte(), !end_bare && (k == len - 1), 1'b0, 1'b0, '0);
          words_left--;
        end
        if (end_bare) begin
          send_word(pick_byte(), 1'b1, 1'b1, 1'b0, '0);
          words_left--;
        end
      end
    end

    drain_hashes();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
